[hw/rtl/vmmio_pkg.sv]
// Shared types and constants of the virtio-mmio register file.
`timescale 1ns / 1ps
`default_nettype none

package vmmio_pkg;

  // Item commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_IRQ   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEVICE_TYPE   = 3'd0;
  localparam logic [2:0] CFG_FEATURES_LOW  = 3'd1;
  localparam logic [2:0] CFG_FEATURES_HIGH = 3'd2;
  localparam logic [2:0] CFG_QUEUE_COUNT   = 3'd3;
  localparam logic [2:0] CFG_SPACE_LEN     = 3'd4;

  // Register window offsets
  localparam logic [11:0] OFF_MAGIC         = 12'h000;
  localparam logic [11:0] OFF_VERSION       = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID     = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID     = 12'h00C;
  localparam logic [11:0] OFF_DEV_FEAT      = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SEL  = 12'h014;
  localparam logic [11:0] OFF_DRV_FEAT      = 12'h020;
  localparam logic [11:0] OFF_DRV_FEAT_SEL  = 12'h024;
  localparam logic [11:0] OFF_QUEUE_SEL     = 12'h030;
  localparam logic [11:0] OFF_QUEUE_NUM_MAX = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM     = 12'h038;
  localparam logic [11:0] OFF_QUEUE_READY   = 12'h044;
  localparam logic [11:0] OFF_QUEUE_NOTIFY  = 12'h050;
  localparam logic [11:0] OFF_IRQ_STATUS    = 12'h060;
  localparam logic [11:0] OFF_IRQ_ACK       = 12'h064;
  localparam logic [11:0] OFF_STATUS        = 12'h070;
  localparam logic [11:0] OFF_DESC_LO       = 12'h080;
  localparam logic [11:0] OFF_DESC_HI       = 12'h084;
  localparam logic [11:0] OFF_AVAIL_LO      = 12'h090;
  localparam logic [11:0] OFF_AVAIL_HI      = 12'h094;
  localparam logic [11:0] OFF_USED_LO       = 12'h0A0;
  localparam logic [11:0] OFF_USED_HI       = 12'h0A4;
  localparam logic [11:0] OFF_GENERATION    = 12'h0FC;
  localparam logic [11:0] OFF_CFG_BASE      = 12'h100;

  // Fixed register values
  localparam logic [31:0] MAGIC_WORD      = 32'h7472_6976;
  localparam logic [31:0] VERSION_WORD    = 32'd2;
  localparam logic [31:0] VENDOR_WORD     = 32'h554D_4551;
  localparam logic [31:0] GENERATION_WORD = 32'd1;

  // Queue size field holds values up to 65535
  localparam int QSIZE_W = 16;

  // One entry of the per-queue state memory
  typedef struct packed {
    logic               ready;
    logic [QSIZE_W-1:0] size;
    logic [63:0]        desc;
    logic [63:0]        avail;
    logic [63:0]        used;
  } q_entry_t;

endpackage

`default_nettype wire

[hw/rtl/vmmio_queue_mem.sv]
// Per-queue state memory with per-entry valid bits, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none

module vmmio_queue_mem
  import vmmio_pkg::*;
#(
  parameter int MAX_QUEUES = 8,
  parameter int QW         = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [QW-1:0] rd_addr,
  output q_entry_t           rd_entry,
  input  wire logic          wr_en,
  input  wire logic [QW-1:0] wr_addr,
  input  q_entry_t           wr_entry
);

  q_entry_t               mem [MAX_QUEUES];
  logic [MAX_QUEUES-1:0]  valid_r;
  q_entry_t               rd_raw_r;
  logic                   rd_valid_r;

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_valid_r ? rd_raw_r : '0;

endmodule

`default_nettype wire

[hw/rtl/vmmio_cfg_mem.sv]
// Device config space: four byte banks, byte-aligned access of up to 4 bytes.
`timescale 1ns / 1ps
`default_nettype none

module vmmio_cfg_mem
  import vmmio_pkg::*;
#(
  parameter int CONFIG_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        rd_en,
  input  wire logic [11:0] rd_pos,
  input  wire logic [2:0]  rd_size,
  output logic      [31:0] rd_data,
  input  wire logic        wr_en,
  input  wire logic [11:0] wr_pos,
  input  wire logic [2:0]  wr_size,
  input  wire logic [31:0] wr_data,
  output logic             busy
);

  localparam int ROWS = (CONFIG_BYTES + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [RW-1:0] clr_row_r;
  logic          clr_busy_r;
  logic [1:0]    rd_lo_r;
  logic [7:0]    bank_rd [4];

  // Clearing pass after reset, one row of all banks a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_row_r == RW'(ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

  assign busy = clr_busy_r;

  // Byte lane of the first read byte, for realignment
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= rd_pos[1:0];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]  mem [ROWS];
    logic [7:0]  rq_r;
    logic [1:0]  rlane;
    logic [1:0]  wlane;
    logic [12:0] rsum;
    logic [12:0] wsum;
    logic [RW-1:0] rrow;
    logic [RW-1:0] wrow;
    logic        ren;
    logic        wen;

    // Which access byte lands in this bank, and at which row
    always_comb begin
      rlane = 2'(b) - rd_pos[1:0];
      wlane = 2'(b) - wr_pos[1:0];
      rsum  = {1'b0, rd_pos} + 13'(rlane);
      wsum  = {1'b0, wr_pos} + 13'(wlane);
      rrow  = rsum[RW+1:2];
      wrow  = wsum[RW+1:2];
      ren   = rd_en && ({1'b0, rlane} < rd_size);
      wen   = wr_en && ({1'b0, wlane} < wr_size);
    end

    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        mem[clr_row_r] <= 8'h00;
      end else if (wen) begin
        mem[wrow] <= wr_data[{wlane, 3'b000} +: 8];
      end
      if (ren) begin
        rq_r <= mem[rrow];
      end
    end

    assign bank_rd[b] = rq_r;
  end

  // Put byte i of the access in byte lane i of the word
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_data[8*i +: 8] = bank_rd[2'(rd_lo_r + 2'(i))];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/virtio_mmio_register_file.sv]
// Top level of the virtio-mmio (version 2) transport register file.
// Usage:
//   Input channel (in_*): one item is a bus read, a bus write or a backend
//   command that sets interrupt status bits. It is taken when in_valid is
//   high and in_stall is low.
//   Result channel (out_*): one result per item: read data, queue notify,
//   reset request and the interrupt-pending flag after the item.
//   Config port (cfg_*): device type, features, queue count and config space
//   length; always ready; the user must write it only while no item is in flight (not enforced).
// Timing:
//   An item is registered when taken; its result is registered in the output
//   register when the item completes. The block takes one item at a time:
//   queue state and config space sit in memories read when the item is taken
//   and written back as it completes; the next item waits for that write-back.
//   The output register lets one new item in while a result waits; when
//   out_stall holds the result, the item behind it holds in place.
// Reset:
//   Registers go to their reset values. The config space memory is then
//   zeroed row by row, with in_stall high throughout.
`timescale 1ns / 1ps
`default_nettype none

module virtio_mmio_register_file
  import vmmio_pkg::*;
#(
  parameter int MAX_QUEUES     = 8,
  parameter int QUEUE_SIZE_MAX = 256,
  parameter int CONFIG_BYTES   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [11:0] in_offset,
  input  wire logic [31:0] in_wdata,
  input  wire logic [2:0]  in_access_size,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_rdata,
  output logic             out_notify_valid,
  output logic      [2:0]  out_notify_queue,
  output logic             out_reset_request,
  output logic             out_irq_pending,
  // configuration port
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  // Configuration registers
  logic [7:0]  device_type_r;
  logic [31:0] features_low_r;
  logic [31:0] features_high_r;
  logic [3:0]  queue_count_r;
  logic [8:0]  cfg_len_r;

  // Transport state
  logic [31:0] queue_select_r,   queue_select_nxt;
  logic [31:0] feature_select_r, feature_select_nxt;
  logic [63:0] drv_features_r,   drv_features_nxt;
  logic [31:0] device_status_r,  device_status_nxt;
  logic [31:0] irq_status_r,     irq_status_nxt;

  // Item in flight
  logic          s1_valid_r;
  logic [1:0]    s1_cmd_r;
  logic [11:0]   s1_off_r;
  logic [31:0]   s1_wdata_r;
  logic [2:0]    s1_size_r;
  logic          s1_cfg_hit_r;
  logic          s1_qv_r;
  logic [QW-1:0] s1_q_r;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_rdata_r;
  logic        out_notify_valid_r;
  logic [2:0]  out_notify_queue_r;
  logic        out_reset_request_r;
  logic        out_irq_pending_r;

  logic          in_acc;
  logic          done;
  logic          cfg_busy;
  logic [4:0]    live_queues;
  logic [11:0]   live_len;
  logic          qv_a;
  logic [QW-1:0] q_a;
  logic [12:0]   pos_a;
  logic          hit_a;
  logic [12:0]   pos_b;

  q_entry_t      q_rd_entry;
  q_entry_t      q_wr_entry;
  logic          q_we;
  logic [31:0]   cfg_rd_word;
  logic          cfg_we;
  logic [31:0]   rdata_b;
  logic          notify_b;
  logic          reset_req_b;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_type_r   <= 8'd2;
      features_low_r  <= 32'd3;
      features_high_r <= 32'd0;
      queue_count_r   <= 4'd1;
      cfg_len_r       <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_TYPE:   device_type_r   <= cfg_wdata[7:0];
        CFG_FEATURES_LOW:  features_low_r  <= cfg_wdata;
        CFG_FEATURES_HIGH: features_high_r <= cfg_wdata;
        CFG_QUEUE_COUNT:   queue_count_r   <= cfg_wdata[3:0];
        CFG_SPACE_LEN:     cfg_len_r       <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Effective queue count and config space length
  always_comb begin
    live_queues = (32'(queue_count_r) < 32'(MAX_QUEUES)) ? 5'(queue_count_r)
                                                         : 5'(MAX_QUEUES);
    live_len    = (32'(cfg_len_r) < 32'(CONFIG_BYTES)) ? 12'(cfg_len_r)
                                                       : 12'(CONFIG_BYTES);
  end

  // Accept: one item at a time, none during the clearing pass
  assign in_stall = s1_valid_r || cfg_busy;
  assign in_acc   = in_valid && !in_stall;
  assign done     = s1_valid_r && (!out_valid_r || !out_stall);

  // Queue selection and config space hit, worked out at accept
  always_comb begin
    qv_a  = queue_select_r < 32'(live_queues);
    q_a   = qv_a ? queue_select_r[QW-1:0] : '0;
    pos_a = {1'b0, in_offset} - {1'b0, OFF_CFG_BASE};
    hit_a = (in_offset >= OFF_CFG_BASE) && (in_access_size >= 3'd1) &&
            (in_access_size <= 3'd4) &&
            ((pos_a + 13'(in_access_size)) <= {1'b0, live_len});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r     <= in_cmd;
      s1_off_r     <= in_offset;
      s1_wdata_r   <= in_wdata;
      s1_size_r    <= in_access_size;
      s1_cfg_hit_r <= hit_a;
      s1_qv_r      <= qv_a;
      s1_q_r       <= q_a;
    end
  end

  assign pos_b = {1'b0, s1_off_r} - {1'b0, OFF_CFG_BASE};

  vmmio_queue_mem #(
    .MAX_QUEUES (MAX_QUEUES),
    .QW         (QW)
  ) u_queue_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc && qv_a),
    .rd_addr  (q_a),
    .rd_entry (q_rd_entry),
    .wr_en    (q_we),
    .wr_addr  (s1_q_r),
    .wr_entry (q_wr_entry)
  );

  vmmio_cfg_mem #(
    .CONFIG_BYTES (CONFIG_BYTES)
  ) u_cfg_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && (in_cmd == CMD_READ) && hit_a),
    .rd_pos  (pos_a[11:0]),
    .rd_size (in_access_size),
    .rd_data (cfg_rd_word),
    .wr_en   (cfg_we),
    .wr_pos  (pos_b[11:0]),
    .wr_size (s1_size_r),
    .wr_data (s1_wdata_r),
    .busy    (cfg_busy)
  );

  // Read data of the item in flight
  always_comb begin
    logic [31:0] word;
    logic [31:0] cfg_word;
    cfg_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (s1_cfg_hit_r && (3'(i) < s1_size_r)) begin
        cfg_word[8*i +: 8] = cfg_rd_word[8*i +: 8];
      end
    end
    unique case (s1_off_r) inside
      OFF_MAGIC:         word = MAGIC_WORD;
      OFF_VERSION:       word = VERSION_WORD;
      OFF_DEVICE_ID:     word = {24'd0, device_type_r};
      OFF_VENDOR_ID:     word = VENDOR_WORD;
      OFF_DEV_FEAT:      word = (feature_select_r == 32'd0) ? features_low_r  :
                                (feature_select_r == 32'd1) ? features_high_r : 32'd0;
      OFF_QUEUE_NUM_MAX: word = s1_qv_r ? 32'(QUEUE_SIZE_MAX) : 32'd0;
      OFF_QUEUE_READY:   word = s1_qv_r ? {31'd0, q_rd_entry.ready} : 32'd0;
      OFF_IRQ_STATUS:    word = irq_status_r;
      OFF_STATUS:        word = device_status_r;
      OFF_GENERATION:    word = GENERATION_WORD;
      default:           word = cfg_word;
    endcase
    rdata_b = (s1_cmd_r == CMD_READ) ? word : 32'd0;
  end

  // Register updates and queue entry modify for the item in flight
  always_comb begin
    logic qw;
    queue_select_nxt   = queue_select_r;
    feature_select_nxt = feature_select_r;
    drv_features_nxt   = drv_features_r;
    device_status_nxt  = device_status_r;
    irq_status_nxt     = irq_status_r;
    q_wr_entry         = q_rd_entry;
    qw                 = 1'b0;
    notify_b           = 1'b0;
    reset_req_b        = 1'b0;
    if (s1_cmd_r == CMD_WRITE) begin
      unique case (s1_off_r) inside
        OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL: feature_select_nxt = s1_wdata_r;
        OFF_DRV_FEAT: begin
          if (feature_select_r == 32'd0) begin
            drv_features_nxt[31:0] = s1_wdata_r;
          end else if (feature_select_r == 32'd1) begin
            drv_features_nxt[63:32] = s1_wdata_r;
          end
        end
        OFF_QUEUE_SEL: queue_select_nxt = s1_wdata_r;
        OFF_QUEUE_NUM: begin
          if (s1_wdata_r <= 32'(QUEUE_SIZE_MAX)) begin
            q_wr_entry.size = s1_wdata_r[QSIZE_W-1:0];
            qw              = 1'b1;
          end
        end
        OFF_QUEUE_READY: begin
          q_wr_entry.ready = |s1_wdata_r;
          qw               = 1'b1;
        end
        OFF_QUEUE_NOTIFY: notify_b = s1_wdata_r < 32'(live_queues);
        OFF_IRQ_ACK:      irq_status_nxt = irq_status_r & ~s1_wdata_r;
        OFF_STATUS: begin
          device_status_nxt = s1_wdata_r;
          reset_req_b       = s1_wdata_r == 32'd0;
        end
        OFF_DESC_LO: begin
          q_wr_entry.desc[31:0] = s1_wdata_r;
          qw                    = 1'b1;
        end
        OFF_DESC_HI: begin
          q_wr_entry.desc[63:32] = s1_wdata_r;
          qw                     = 1'b1;
        end
        OFF_AVAIL_LO: begin
          q_wr_entry.avail[31:0] = s1_wdata_r;
          qw                     = 1'b1;
        end
        OFF_AVAIL_HI: begin
          q_wr_entry.avail[63:32] = s1_wdata_r;
          qw                      = 1'b1;
        end
        OFF_USED_LO: begin
          q_wr_entry.used[31:0] = s1_wdata_r;
          qw                    = 1'b1;
        end
        OFF_USED_HI: begin
          q_wr_entry.used[63:32] = s1_wdata_r;
          qw                     = 1'b1;
        end
        default: ;
      endcase
    end else if (s1_cmd_r == CMD_IRQ) begin
      irq_status_nxt = irq_status_r | s1_wdata_r;
    end
    q_we = done && qw && s1_qv_r;
  end

  // Config space write-back
  assign cfg_we = done && (s1_cmd_r == CMD_WRITE) && s1_cfg_hit_r;

  // Transport state commits when the item completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_select_r   <= '0;
      feature_select_r <= '0;
      drv_features_r   <= '0;
      device_status_r  <= '0;
      irq_status_r     <= '0;
    end else if (done) begin
      queue_select_r   <= queue_select_nxt;
      feature_select_r <= feature_select_nxt;
      drv_features_r   <= drv_features_nxt;
      device_status_r  <= device_status_nxt;
      irq_status_r     <= irq_status_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_rdata_r         <= rdata_b;
      out_notify_valid_r  <= notify_b;
      out_notify_queue_r  <= notify_b ? s1_wdata_r[2:0] : 3'd0;
      out_reset_request_r <= reset_req_b;
      out_irq_pending_r   <= |irq_status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_rdata_r;
  assign out_notify_valid  = out_notify_valid_r;
  assign out_notify_queue  = out_notify_queue_r;
  assign out_reset_request = out_reset_request_r;
  assign out_irq_pending   = out_irq_pending_r;

endmodule

`default_nettype wire
